/* hw/rtl/lfd_pkg.sv */
package lfd_pkg;

    localparam int BODY_BYTES_DEF = 31;
    localparam int POINTS_DEF     = 8;

    localparam logic [31:0] HEADER_RESET = 32'h55AA_0308;
    localparam logic signed [16:0] THRESH_RESET = 17'sd11520;
    localparam logic signed [16:0] ANGLE_OFFSET = 17'sd40960;

    localparam int OFF_SPEED  = 0;
    localparam int OFF_START  = 2;
    localparam int OFF_POINTS = 4;
    localparam int OFF_END    = 28;

    localparam int BYTES_PER_POINT = 3;

    typedef enum logic [0:0] {
        REG_HEADER = 1'b0,
        REG_THRESH = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_BODY,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_LOAD
    } state_t;

endpackage

/* hw/rtl/lfd_ram.sv */
module lfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/lidar_frame_deframer.sv */
// lidar frame deframer
// rx channel (rx_byte, rx_valid, rx_stall): one received byte per transaction.
// while hunting, bytes are compared against header_word, first byte in bits
// 31..24; a mismatch restarts the match. after the header the body bytes are
// written to the body RAM one per cycle, with no check for headers.
// header and body bytes are taken with no stall. the last body byte
// starts a readout of the point bytes from the body RAM through its single
// read port: three reads and a load of the output register per point, for
// all eight points, during which rx_stall is high. the first point is valid
// once its output register is loaded.
// point channel (point_valid, point_stall): one point per transaction, the
// final one flagged by last; a point is held in an output register, and a
// stall on it holds the readout before the next load. after the final point
// is loaded the block takes bytes again while that point is still waiting.
// config: APB, header_word at 0x0 and rotation_threshold at 0x4, pready high.
// reset: back to hunting, match and body counters cleared, previous start
// angle zero, registers at their defaults; the body RAM is not cleared, as
// every entry read is written earlier in the same frame.
module lidar_frame_deframer #(
    parameter int BODY_BYTES = lfd_pkg::BODY_BYTES_DEF,
    parameter int POINTS     = lfd_pkg::POINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic [7:0]         rx_byte,
    input  logic               rx_valid,
    output logic               rx_stall,
    output logic [2:0]         point_number,
    output logic [15:0]        distance,
    output logic [7:0]         quality,
    output logic signed [16:0] scan_start,
    output logic signed [16:0] scan_end,
    output logic [15:0]        speed_raw,
    output logic               rotation,
    output logic               last,
    output logic               point_valid,
    input  logic               point_stall
);

    localparam int AW = $clog2(BODY_BYTES);
    localparam logic [AW-1:0] IDX_LAST     = AW'(BODY_BYTES - 1);
    localparam logic [AW-1:0] IDX_SPEED_LO = AW'(lfd_pkg::OFF_SPEED);
    localparam logic [AW-1:0] IDX_SPEED_HI = AW'(lfd_pkg::OFF_SPEED + 1);
    localparam logic [AW-1:0] IDX_START_LO = AW'(lfd_pkg::OFF_START);
    localparam logic [AW-1:0] IDX_START_HI = AW'(lfd_pkg::OFF_START + 1);
    localparam logic [AW-1:0] IDX_END_LO   = AW'(lfd_pkg::OFF_END);
    localparam logic [AW-1:0] IDX_END_HI   = AW'(lfd_pkg::OFF_END + 1);
    localparam logic [AW-1:0] IDX_POINTS   = AW'(lfd_pkg::OFF_POINTS);
    localparam logic [2:0]    PT_LAST      = 3'(POINTS - 1);

    lfd_pkg::state_t state_reg, state_next;

    logic [31:0]        header_reg;
    logic signed [16:0] thresh_reg;
    logic [1:0]         match_reg;
    logic [AW-1:0]      body_idx_reg;
    logic [AW-1:0]      addr_reg;
    logic [2:0]         pt_reg;
    logic signed [16:0] prev_start_reg;
    logic [15:0]        speed_word_reg;
    logic [15:0]        start_word_reg;
    logic [15:0]        end_word_reg;
    logic signed [16:0] start_reg;
    logic               rot_reg;
    logic [7:0]         lo_reg;
    logic [7:0]         hi_reg;

    logic [2:0]         point_number_reg;
    logic [15:0]        distance_reg;
    logic [7:0]         quality_reg;
    logic signed [16:0] scan_start_reg;
    logic signed [16:0] scan_end_reg;
    logic [15:0]        speed_raw_reg;
    logic               rotation_reg;
    logic               last_reg;
    logic               point_valid_reg;

    logic               cfg_wr;
    lfd_pkg::reg_idx_t  cfg_idx;
    logic               rx_accept;
    logic               hdr_match;
    logic [7:0]         want;
    logic               body_last;
    logic               out_free;
    logic               ram_we;
    logic               ram_re;
    logic               load;
    logic [7:0]         ram_rdata;
    logic signed [16:0] start_conv;
    logic signed [16:0] end_conv;

    lfd_ram #(
        .WIDTH (8),
        .DEPTH (BODY_BYTES)
    ) u_body_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (body_idx_reg),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // config port
    assign cfg_idx = lfd_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (cfg_idx)
            lfd_pkg::REG_HEADER: prdata = header_reg;
            lfd_pkg::REG_THRESH: prdata = {{15{thresh_reg[16]}}, thresh_reg};
            default:             prdata = header_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= lfd_pkg::HEADER_RESET;
            thresh_reg <= lfd_pkg::THRESH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                lfd_pkg::REG_HEADER: header_reg <= pwdata;
                lfd_pkg::REG_THRESH: thresh_reg <= $signed(pwdata[16:0]);
                default:             header_reg <= header_reg;
            endcase
        end
    end

    // header byte selection
    always_comb
    begin
        unique case (match_reg)
            2'd0:    want = header_reg[31:24];
            2'd1:    want = header_reg[23:16];
            2'd2:    want = header_reg[15:8];
            2'd3:    want = header_reg[7:0];
            default: want = header_reg[31:24];
        endcase
    end

    assign rx_accept  = rx_valid && !rx_stall;
    assign hdr_match  = (rx_byte == want);
    assign body_last  = (body_idx_reg == IDX_LAST);
    assign out_free   = !point_valid_reg || !point_stall;
    assign start_conv = $signed({1'b0, start_word_reg}) - lfd_pkg::ANGLE_OFFSET;
    assign end_conv   = $signed({1'b0, end_word_reg}) - lfd_pkg::ANGLE_OFFSET;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfd_pkg::ST_HUNT:
            begin
                if (rx_accept && hdr_match && (match_reg == 2'd3))
                begin
                    state_next = lfd_pkg::ST_BODY;
                end
            end
            lfd_pkg::ST_BODY:
            begin
                if (rx_accept && body_last)
                begin
                    state_next = lfd_pkg::ST_RD0;
                end
            end
            lfd_pkg::ST_RD0: state_next = lfd_pkg::ST_RD1;
            lfd_pkg::ST_RD1: state_next = lfd_pkg::ST_RD2;
            lfd_pkg::ST_RD2: state_next = lfd_pkg::ST_LOAD;
            lfd_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = (pt_reg == PT_LAST) ? lfd_pkg::ST_HUNT : lfd_pkg::ST_RD0;
                end
            end
            default: state_next = lfd_pkg::ST_HUNT;
        endcase
    end

    // state outputs
    always_comb
    begin
        rx_stall = 1'b1;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        load     = 1'b0;
        unique case (state_reg)
            lfd_pkg::ST_HUNT: rx_stall = 1'b0;
            lfd_pkg::ST_BODY:
            begin
                rx_stall = 1'b0;
                ram_we   = rx_valid;
            end
            lfd_pkg::ST_RD0,
            lfd_pkg::ST_RD1,
            lfd_pkg::ST_RD2: ram_re = 1'b1;
            lfd_pkg::ST_LOAD: load = out_free;
            default: rx_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lfd_pkg::ST_HUNT;
            match_reg       <= 2'd0;
            body_idx_reg    <= '0;
            addr_reg        <= '0;
            pt_reg          <= 3'd0;
            prev_start_reg  <= '0;
            point_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rx_accept && (state_reg == lfd_pkg::ST_HUNT))
            begin
                match_reg    <= hdr_match ? match_reg + 2'd1 : 2'd0;
                body_idx_reg <= '0;
            end
            if (ram_we)
            begin
                body_idx_reg <= body_last ? '0 : body_idx_reg + AW'(1);
                if (body_last)
                begin
                    addr_reg       <= IDX_POINTS;
                    pt_reg         <= 3'd0;
                    prev_start_reg <= start_conv;
                end
            end
            if (ram_re)
            begin
                addr_reg <= addr_reg + AW'(1);
            end
            if (load)
            begin
                pt_reg <= pt_reg + 3'd1;
            end
            if (load)
            begin
                point_valid_reg <= 1'b1;
            end
            else if (!point_stall)
            begin
                point_valid_reg <= 1'b0;
            end
        end
    end

    // frame fields and point bytes
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            if (body_idx_reg == IDX_SPEED_LO) speed_word_reg[7:0]  <= rx_byte;
            if (body_idx_reg == IDX_SPEED_HI) speed_word_reg[15:8] <= rx_byte;
            if (body_idx_reg == IDX_START_LO) start_word_reg[7:0]  <= rx_byte;
            if (body_idx_reg == IDX_START_HI) start_word_reg[15:8] <= rx_byte;
            if (body_idx_reg == IDX_END_LO)   end_word_reg[7:0]    <= rx_byte;
            if (body_idx_reg == IDX_END_HI)   end_word_reg[15:8]   <= rx_byte;
            if (body_last)
            begin
                start_reg <= start_conv;
                rot_reg   <= (prev_start_reg <= thresh_reg) && (start_conv >= thresh_reg);
            end
        end
        if (state_reg == lfd_pkg::ST_RD1)
        begin
            lo_reg <= ram_rdata;
        end
        if (state_reg == lfd_pkg::ST_RD2)
        begin
            hi_reg <= ram_rdata;
        end
        if (load)
        begin
            point_number_reg <= pt_reg;
            distance_reg     <= {hi_reg, lo_reg};
            quality_reg      <= ram_rdata;
            scan_start_reg   <= start_reg;
            scan_end_reg     <= end_conv;
            speed_raw_reg    <= speed_word_reg;
            rotation_reg     <= rot_reg;
            last_reg         <= (pt_reg == PT_LAST);
        end
    end

    assign point_number = point_number_reg;
    assign distance     = distance_reg;
    assign quality      = quality_reg;
    assign scan_start   = scan_start_reg;
    assign scan_end     = scan_end_reg;
    assign speed_raw    = speed_raw_reg;
    assign rotation     = rotation_reg;
    assign last         = last_reg;
    assign point_valid  = point_valid_reg;

endmodule

/* hw/rtl/lfd_checker.sv */
module lfd_checker #(
    parameter int POINTS = lfd_pkg::POINTS_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               rx_stall,
    input logic [2:0]         point_number,
    input logic [15:0]        distance,
    input logic [7:0]         quality,
    input logic signed [16:0] scan_start,
    input logic signed [16:0] scan_end,
    input logic [15:0]        speed_raw,
    input logic               rotation,
    input logic               last,
    input logic               point_valid,
    input logic               point_stall
);

    localparam logic [2:0] PT_LAST = 3'(POINTS - 1);

    // a stalled point holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> point_valid && $stable(point_number)
        && $stable(distance) && $stable(quality) && $stable(scan_start)
        && $stable(scan_end) && $stable(speed_raw) && $stable(rotation) && $stable(last))
        else $error("stalled point changed");

    // last flag marks the final point number
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> (last == (point_number == PT_LAST)))
        else $error("last flag and point number disagree");

    // no bytes taken while a frame is being read out
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !last |-> rx_stall)
        else $error("byte taken during frame readout");

    // frame fields stay the same across the points of one frame
    a_frame: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall && !last ##1 point_valid |->
        $stable(scan_start) && $stable(scan_end) && $stable(speed_raw) && $stable(rotation))
        else $error("frame fields changed within a frame");

endmodule

bind lidar_frame_deframer lfd_checker #(.POINTS(POINTS)) u_lfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_stall     (rx_stall),
    .point_number (point_number),
    .distance     (distance),
    .quality      (quality),
    .scan_start   (scan_start),
    .scan_end     (scan_end),
    .speed_raw    (speed_raw),
    .rotation     (rotation),
    .last         (last),
    .point_valid  (point_valid),
    .point_stall  (point_stall)
);

/* tb/sv/lidar_frame_deframer_tb.sv */
module lidar_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BODY       = lfd_pkg::BODY_BYTES_DEF;
    localparam int NPTS       = lfd_pkg::POINTS_DEF;
    localparam int SETTLE     = 48;
    localparam int LONG_HOLD  = 400;
    localparam int NPHASES    = 6;
    localparam int PHASE_FILL = 30;
    localparam longint TIMEOUT_NS = 3_000_000;

    typedef struct {
        logic [2:0]         point_number;
        logic [15:0]        distance;
        logic [7:0]         quality;
        logic signed [16:0] scan_start;
        logic signed [16:0] scan_end;
        logic [15:0]        speed_raw;
        logic               rotation;
        logic               last;
    } point_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic [7:0]         rx_byte = '0;
    logic               rx_valid = 1'b0;
    logic               rx_stall;
    logic [2:0]         point_number;
    logic [15:0]        distance;
    logic [7:0]         quality;
    logic signed [16:0] scan_start;
    logic signed [16:0] scan_end;
    logic [15:0]        speed_raw;
    logic               rotation;
    logic               last;
    logic               point_valid;
    logic               point_stall = 1'b0;

    lidar_frame_deframer u_dut (.*);

    // predictor state and shadow registers
    logic [31:0]        hdr_word;
    logic signed [16:0] thr_reg;
    logic               hunting;
    int                 hdr_pos;
    int                 body_pos;
    logic [7:0]         body_mem [BODY];
    int                 prev_start;

    logic [7:0] byte_q [$];
    point_t     point_q [$];

    bit idle_mode = 1'b1;
    int tx_gap = 0;
    int rx_hold = 0;
    int long_req = 0;
    int long_done = 0;

    int fail_count = 0;
    int bytes_accepted = 0;
    int points_checked = 0;
    int frames_done = 0;
    int rot_frames = 0;

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (!idle_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        point_t     pt;
        int         start_i;
        int         end_i;
        int         base;
        logic       rot;
        logic [7:0] want;
        if (hunting)
        begin
            want = hdr_word[31 - 8 * hdr_pos -: 8];
            if (b == want)
            begin
                if (hdr_pos == 3)
                begin
                    hdr_pos  = 0;
                    hunting  = 1'b0;
                    body_pos = 0;
                end
                else
                    hdr_pos++;
            end
            else
                hdr_pos = 0;
            return;
        end
        body_mem[body_pos] = b;
        body_pos++;
        if (body_pos < BODY)
            return;
        body_pos = 0;
        hunting  = 1'b1;
        start_i = int'({body_mem[lfd_pkg::OFF_START + 1], body_mem[lfd_pkg::OFF_START]})
                  - int'(lfd_pkg::ANGLE_OFFSET);
        end_i   = int'({body_mem[lfd_pkg::OFF_END + 1], body_mem[lfd_pkg::OFF_END]})
                  - int'(lfd_pkg::ANGLE_OFFSET);
        rot = (prev_start <= int'(thr_reg)) && (start_i >= int'(thr_reg));
        for (int i = 0; i < NPTS; i++)
        begin
            base = lfd_pkg::OFF_POINTS + lfd_pkg::BYTES_PER_POINT * i;
            pt.point_number = i[2:0];
            pt.distance     = {body_mem[base + 1], body_mem[base]};
            pt.quality      = body_mem[base + 2];
            pt.scan_start   = start_i[16:0];
            pt.scan_end     = end_i[16:0];
            pt.speed_raw    = {body_mem[lfd_pkg::OFF_SPEED + 1], body_mem[lfd_pkg::OFF_SPEED]};
            pt.rotation     = rot;
            pt.last         = (i == NPTS - 1);
            point_q.push_back(pt);
        end
        prev_start = start_i;
        frames_done++;
        if (rot)
            rot_frames++;
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] exp_v,
                                        input logic signed [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // byte driver
    always @(posedge clk)
    begin
        if (rst_n && rx_valid && !rx_stall)
        begin
            deframe_byte(rx_byte);
            bytes_accepted++;
            tx_gap = pick_gap();
        end
        if (!rx_valid || !rx_stall)
        begin
            if (tx_gap > 0)
            begin
                rx_valid <= 1'b0;
                tx_gap--;
            end
            else if (byte_q.size() > 0)
            begin
                rx_byte  <= byte_q.pop_front();
                rx_valid <= 1'b1;
            end
            else
                rx_valid <= 1'b0;
        end
    end

    // point monitor and point_stall driver
    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && point_valid && !point_stall)
        begin
            if (point_q.size() == 0)
            begin
                $error("point transaction with nothing expected: point_number %0d", point_number);
                fail_count++;
            end
            else
            begin
                e = point_q.pop_front();
                check_field("point_number", e.point_number, point_number);
                check_field("distance", e.distance, distance);
                check_field("quality", e.quality, quality);
                check_field("scan_start", e.scan_start, scan_start);
                check_field("scan_end", e.scan_end, scan_end);
                check_field("speed_raw", e.speed_raw, speed_raw);
                check_field("rotation", e.rotation, rotation);
                check_field("last", e.last, last);
                points_checked++;
            end
        end
        if (long_done != long_req)
        begin
            long_done = long_req;
            rx_hold   = LONG_HOLD;
        end
        if (rx_hold > 0)
        begin
            point_stall <= 1'b1;
            rx_hold--;
        end
        else
        begin
            point_stall <= 1'b0;
            if (idle_mode && $urandom_range(0, 3) == 0)
                rx_hold = pick_gap();
        end
    end

    task automatic apb_write(input lfd_pkg::reg_idx_t idx, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == lfd_pkg::REG_HEADER)
            hdr_word = data;
        else
            thr_reg = data[16:0];
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while (byte_q.size() > 0 || rx_valid || point_q.size() > 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic push_header(input int n);
        for (int j = 0; j < n; j++)
            byte_q.push_back(hdr_word[31 - 8 * j -: 8]);
    endtask

    task automatic add_random_bytes(input int n);
        int         added;
        int         kind;
        int         sel;
        int         k;
        int         w;
        logic [7:0] body [BODY];
        added = 0;
        while (added < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                foreach (body[j])
                    body[j] = 8'($urandom_range(0, 255));
                sel = $urandom_range(0, 9);
                if (sel < 3)
                begin
                    w = int'(thr_reg) + int'(lfd_pkg::ANGLE_OFFSET) + $urandom_range(0, 2) - 1;
                    if (w >= 0 && w <= 65535)
                        {body[lfd_pkg::OFF_START + 1], body[lfd_pkg::OFF_START]} = w[15:0];
                end
                else if (sel == 3)
                    {body[lfd_pkg::OFF_START + 1], body[lfd_pkg::OFF_START]} =
                        $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                push_header(4);
                foreach (body[j])
                    byte_q.push_back(body[j]);
                added += 4 + BODY;
            end
            else if (kind < 85)
            begin
                k = $urandom_range(1, 6);
                repeat (k) byte_q.push_back(8'($urandom_range(0, 255)));
                added += k;
            end
            else
            begin
                // header cut short by a stray byte
                k = $urandom_range(1, 3);
                push_header(k);
                byte_q.push_back(8'($urandom_range(0, 255)));
                added += k + 1;
            end
        end
    endtask

    initial
    begin
        logic [31:0]        hdr_set [NPHASES];
        logic signed [16:0] thr_set [NPHASES];
        hdr_set = '{lfd_pkg::HEADER_RESET, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0,
                    lfd_pkg::HEADER_RESET};
        thr_set = '{lfd_pkg::THRESH_RESET, -17'sd40960, 17'sd24575, 17'h10000, 17'h0FFFF,
                    17'h0};
        hdr_set[3] = $urandom;
        hdr_set[4] = $urandom;
        thr_set[5] = 17'($urandom_range(0, 17'h1FFFF));

        hdr_word   = lfd_pkg::HEADER_RESET;
        thr_reg    = lfd_pkg::THRESH_RESET;
        hunting    = 1'b1;
        hdr_pos    = 0;
        body_pos   = 0;
        prev_start = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes: all-ones body, rotation from the reset start angle
        push_header(4);
        repeat (BODY) byte_q.push_back(8'hFF);
        // mismatch on the last header byte, then an all-zero body
        push_header(3);
        push_header(3);
        byte_q.push_back(hdr_word[7:0]);
        push_header(4);
        repeat (BODY) byte_q.push_back(8'h00);
        // repeated first byte, then a body that carries the header itself
        push_header(1);
        push_header(4);
        push_header(4);
        push_header(4);
        repeat (BODY - 4) byte_q.push_back(8'($urandom_range(0, 255)));

        for (int p = 0; p < NPHASES; p++)
        begin
            if (p > 0)
            begin
                wait_drain();
                apb_write(lfd_pkg::REG_HEADER, hdr_set[p]);
                apb_write(lfd_pkg::REG_THRESH, {15'($urandom), thr_set[p]});
            end
            idle_mode = (p != 1 && p != 5);
            if (p == 2)
                long_req++;
            add_random_bytes(PHASE_FILL);
            if (p == 3)
                wait_drain();
            if (p > 0 && p < NPHASES - 1)
                add_random_bytes(PHASE_FILL);
        end
        wait_drain();

        $display("run covered %0d bytes and %0d frames, %0d of them completing a rotation",
                 bytes_accepted, frames_done, rot_frames);
        $display("%0d points checked across %0d register settings", points_checked, NPHASES);
        if (fail_count == 0)
            $display("lidar_frame_deframer_tb: PASS");
        else
            $display("lidar_frame_deframer_tb: FAIL");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d bytes pending and %0d points outstanding",
                 byte_q.size(), point_q.size());
        $display("lidar_frame_deframer_tb: FAIL");
        $finish;
    end

endmodule

/* lidar_frame_deframer.f */
hw/rtl/lfd_pkg.sv
hw/rtl/lfd_ram.sv
hw/rtl/lidar_frame_deframer.sv
hw/rtl/lfd_checker.sv
tb/sv/lidar_frame_deframer_tb.sv
